FILE: hw/rtl/jtm_pkg.sv
package jtm_pkg;

    // Field widths.
    localparam int ADC_BITS   = 14;
    localparam int CUR_W      = 7;
    localparam int COEF_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 8;
    localparam int STEP_LIMIT = 127;

    // Datapath widths derived from the field widths.
    localparam int OFF_W  = ADC_BITS + 1;          // signed axis offset
    localparam int NSUM_W = ADC_BITS + 2;          // offset plus axis span, signed
    localparam int NABS_W = ADC_BITS + 1;          // magnitude of that sum
    localparam int PROD_W = NABS_W + CUR_W;        // linear numerator
    localparam int ACC_W  = COEF_W + 2 * ADC_BITS + 2;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    typedef logic [ADC_BITS-1:0]      t_adc;
    typedef logic signed [OFF_W-1:0]  t_offset;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [STEP_W-1:0] t_step;
    typedef logic [CUR_W-1:0]         t_cursor;

    typedef enum logic [2:0] {
        CFG_MAPPING_MODE = 3'd0,
        CFG_AXIS_CENTRE  = 3'd1,
        CFG_DEAD_ZONE    = 3'd2,
        CFG_AXIS_SPAN    = 3'd3,
        CFG_CURSOR_SPAN  = 3'd4,
        CFG_COEF_SQUARE  = 3'd5,
        CFG_COEF_LINEAR  = 3'd6,
        CFG_COEF_OFFSET  = 3'd7
    } t_cfg_idx;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_POLY   = 1'b1;

    localparam t_adc    CENTRE_RST = t_adc'(8192);
    localparam t_adc    SPAN_RST   = t_adc'(8192);
    localparam t_cursor CURSOR_RST = t_cursor'(10);
    localparam t_coef   COEF_LINEAR_RST = t_coef'(1);

    typedef struct packed {
        logic    mapping_mode;
        t_adc    dead_zone;
        t_adc    axis_span;
        t_cursor cursor_span;
        t_coef   coef_square;
        t_coef   coef_linear;
        t_coef   coef_offset;
    } t_cfg;

    typedef struct packed {
        logic button_level;
        t_adc x_reading;
        t_adc y_reading;
    } t_in_item;

    typedef struct packed {
        logic  button_changed;
        logic  button_now;
        t_step move_x;
        t_step move_y;
        logic  moved;
        logic  action_seen;
    } t_out_item;

    typedef struct packed {
        logic  busy;
        t_step step;
    } t_axis_res;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MUL_LIN,
        PH_POLY1,
        PH_POLY2,
        PH_DIV,
        PH_FIN
    } t_phase;

endpackage

FILE: hw/rtl/jtm_in_if.sv
interface jtm_in_if;
    import jtm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/jtm_out_if.sv
interface jtm_out_if;
    import jtm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/jtm_cfg_if.sv
interface jtm_cfg_if;
    import jtm_pkg::*;

    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/jtm_axis.sv
module jtm_axis (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  jtm_pkg::t_offset   i_offset,
    input  jtm_pkg::t_cfg      i_cfg,
    output jtm_pkg::t_axis_res o_res
);
    import jtm_pkg::*;

    localparam int MUL_W = ADC_BITS;
    localparam logic signed [ACC_W-1:0] STEP_HI = ACC_W'(STEP_LIMIT);
    localparam logic signed [ACC_W-1:0] STEP_LO = -STEP_HI;

    function automatic t_step clamp_step(input logic signed [ACC_W-1:0] v);
        t_step s;
        if (v > STEP_HI) begin
            s = STEP_HI[STEP_W-1:0];
        end else if (v < STEP_LO) begin
            s = STEP_LO[STEP_W-1:0];
        end else begin
            s = v[STEP_W-1:0];
        end
        return s;
    endfunction

    t_phase                    r_phase, n_phase;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [ACC_W-1:0]   r_mcand, n_mcand;
    logic [MUL_W-1:0]          r_mul, n_mul;
    logic [ADC_BITS-1:0]       r_rem, n_rem;
    t_adc                      r_mag, n_mag;
    logic                      r_neg, n_neg;
    logic                      r_zero, n_zero;
    t_step                     r_step, n_step;

    t_offset                   mag_s;
    t_adc                      mag;
    logic                      dead;
    logic signed [NSUM_W-1:0]  sum;
    logic signed [NSUM_W-1:0]  sum_abs;
    logic [NABS_W-1:0]         nabs;
    logic                      last;
    logic signed [ACC_W-1:0]   mul_sum;
    logic [ADC_BITS+1:0]       div_in;
    logic [ADC_BITS+1:0]       trial;
    logic                      q_bit;
    logic [PROD_W-1:0]         q_lin;
    logic signed [PROD_W+1:0]  q_signed;
    logic signed [PROD_W+1:0]  lin_r;
    logic signed [ACC_W-1:0]   poly_v;
    logic signed [ACC_W-1:0]   final_v;

    // Start-time decode of the offset.
    assign mag_s   = i_offset[OFF_W-1] ? -i_offset : i_offset;
    assign mag     = mag_s[ADC_BITS-1:0];
    assign dead    = (mag <= i_cfg.dead_zone);
    assign sum     = $signed({i_offset[OFF_W-1], i_offset}) + $signed({2'b00, i_cfg.axis_span});
    assign sum_abs = sum[NSUM_W-1] ? -sum : sum;
    assign nabs    = sum_abs[NABS_W-1:0];

    // Shift-and-add multiplier step and restoring divider step.
    assign last    = (r_cnt == CNT_W'(1));
    assign mul_sum = r_mul[0] ? (r_acc + r_mcand) : r_acc;
    assign div_in  = {1'b0, r_rem, r_acc[PROD_W-1]};
    assign trial   = div_in - {2'b00, i_cfg.axis_span};
    assign q_bit   = ~trial[ADC_BITS+1];

    // Final sign, bias and saturation.
    assign q_lin    = r_acc[PROD_W-1:0];
    assign q_signed = r_neg ? -$signed({2'b00, q_lin}) : $signed({2'b00, q_lin});
    assign lin_r    = q_signed - $signed({{(PROD_W+2-CUR_W){1'b0}}, i_cfg.cursor_span});
    assign poly_v   = r_neg ? -r_acc : r_acc;
    assign final_v  = (i_cfg.mapping_mode == MODE_POLY) ? poly_v
                    : {{(ACC_W-PROD_W-2){lin_r[PROD_W+1]}}, lin_r};

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    if (dead || (i_cfg.mapping_mode == MODE_LINEAR && i_cfg.axis_span == '0)) begin
                        n_phase = PH_FIN;
                    end else if (i_cfg.mapping_mode == MODE_LINEAR) begin
                        n_phase = PH_MUL_LIN;
                    end else begin
                        n_phase = PH_POLY1;
                    end
                end
            end
            PH_MUL_LIN: if (last) n_phase = PH_DIV;
            PH_POLY1:   if (last) n_phase = PH_POLY2;
            PH_POLY2:   if (last) n_phase = PH_FIN;
            PH_DIV:     if (last) n_phase = PH_FIN;
            PH_FIN:     n_phase = PH_IDLE;
            default:    n_phase = PH_IDLE;
        endcase
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_mul   = r_mul;
        n_rem   = r_rem;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_zero  = r_zero;
        n_step  = r_step;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_zero = dead || (i_cfg.mapping_mode == MODE_LINEAR && i_cfg.axis_span == '0);
                    n_mag  = mag;
                    n_rem  = '0;
                    if (i_cfg.mapping_mode == MODE_LINEAR) begin
                        n_acc   = '0;
                        n_mcand = {{(ACC_W-NABS_W){1'b0}}, nabs};
                        n_mul   = {{(MUL_W-CUR_W){1'b0}}, i_cfg.cursor_span};
                        n_cnt   = CNT_W'(CUR_W);
                        n_neg   = sum[NSUM_W-1];
                    end else begin
                        n_acc   = {{(ACC_W-COEF_W){i_cfg.coef_linear[COEF_W-1]}},
                                   i_cfg.coef_linear};
                        n_mcand = {{(ACC_W-COEF_W){i_cfg.coef_square[COEF_W-1]}},
                                   i_cfg.coef_square};
                        n_mul   = mag;
                        n_cnt   = CNT_W'(ADC_BITS);
                        n_neg   = i_offset[OFF_W-1];
                    end
                end
            end
            PH_MUL_LIN, PH_POLY2: begin
                n_acc   = mul_sum;
                n_mcand = r_mcand <<< 1;
                n_mul   = r_mul >> 1;
                n_cnt   = last ? CNT_W'(PROD_W) : r_cnt - CNT_W'(1);
            end
            PH_POLY1: begin
                if (last) begin
                    // A*m + B is done; it becomes the multiplicand of the second pass.
                    n_mcand = mul_sum;
                    n_acc   = {{(ACC_W-COEF_W){i_cfg.coef_offset[COEF_W-1]}},
                               i_cfg.coef_offset};
                    n_mul   = r_mag;
                    n_cnt   = CNT_W'(ADC_BITS);
                end else begin
                    n_acc   = mul_sum;
                    n_mcand = r_mcand <<< 1;
                    n_mul   = r_mul >> 1;
                    n_cnt   = r_cnt - CNT_W'(1);
                end
            end
            PH_DIV: begin
                n_rem = q_bit ? trial[ADC_BITS-1:0] : div_in[ADC_BITS-1:0];
                n_acc = {r_acc[ACC_W-2:0], q_bit};
                n_cnt = r_cnt - CNT_W'(1);
            end
            PH_FIN: begin
                n_step = r_zero ? '0 : clamp_step(final_v);
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_mul   <= n_mul;
        r_rem   <= n_rem;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_zero  <= n_zero;
        r_step  <= n_step;
    end

    assign o_res.busy = (r_phase != PH_IDLE);
    assign o_res.step = r_step;

endmodule

FILE: hw/rtl/joystick_to_mouse_mapper_core.sv
// Joystick to mouse mapper core.
// Input channel i_in takes one joystick sample per item: the button level and
// the x and y ADC readings. Output channel o_out gives exactly one result item
// per sample: button change and level, the two saturated cursor steps, and the
// moved and action flags. Channel i_cfg writes the eight mapping registers by
// index; it is always ready. It is to be written only while the block is idle;
// the block does not enforce this. Each axis has its own bit-serial unit,
// so both axes are worked in parallel. In linear mode a sample passes through
// a shift-and-add multiply, a restoring divider that produces one quotient
// bit per cycle, a step for sign and saturation, and the load of the output
// register. Polynomial mode runs two Horner passes instead of multiply and
// divide. With both axes in the dead zone, or a zero span in linear mode, the
// axis units skip straight to the final step and give a zero step. One sample
// is in work at a time, and the next can be taken in the cycle after a result
// is loaded.
// The result sits in an output register, so the next sample is accepted while
// a finished result still waits; if the receiver stalls longer, the next
// result is held inside the axis units until the output register frees up.
// Reset restores the register defaults and clears the remembered button level
// to released; no item is in flight after reset.
module joystick_to_mouse_mapper_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jtm_in_if.sink        i_in,
    jtm_out_if.source     o_out,
    jtm_cfg_if.sink       i_cfg
);
    import jtm_pkg::*;

    t_state    r_state, n_state;
    logic      r_last_button;
    logic      r_changed;
    logic      r_btn;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;

    // Configuration registers.
    logic      r_mode;
    t_adc      r_centre;
    t_adc      r_dead_zone;
    t_adc      r_span;
    t_cursor   r_cursor;
    t_coef     r_coef_sq;
    t_coef     r_coef_lin;
    t_coef     r_coef_off;

    logic      in_ready;
    logic      start;
    logic      out_load;
    logic      units_done;
    t_offset   x_offset;
    t_offset   y_offset;
    t_cfg      axis_cfg;
    t_axis_res res_x;
    t_axis_res res_y;

    assign axis_cfg.mapping_mode = r_mode;
    assign axis_cfg.dead_zone    = r_dead_zone;
    assign axis_cfg.axis_span    = r_span;
    assign axis_cfg.cursor_span  = r_cursor;
    assign axis_cfg.coef_square  = r_coef_sq;
    assign axis_cfg.coef_linear  = r_coef_lin;
    assign axis_cfg.coef_offset  = r_coef_off;

    // The y axis runs the other way: an offset is the centre minus the reading.
    assign x_offset = $signed({1'b0, i_in.payload.x_reading}) - $signed({1'b0, r_centre});
    assign y_offset = $signed({1'b0, r_centre}) - $signed({1'b0, i_in.payload.y_reading});

    assign units_done = ~res_x.busy & ~res_y.busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_RUN;
            ST_RUN:  if (units_done && (!r_out_valid || o_out.ready)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_RUN:  out_load = units_done && (!r_out_valid || o_out.ready);
            default: in_ready = 1'b0;
        endcase
    end

    assign start = i_in.valid & in_ready;

    // The output register holds a result until it is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_last_button <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (start) begin
                r_last_button <= i_in.payload.button_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_changed <= i_in.payload.button_level ^ r_last_button;
            r_btn     <= i_in.payload.button_level;
        end
        if (out_load) begin
            r_out.button_changed <= r_changed;
            r_out.button_now     <= r_btn;
            r_out.move_x         <= res_x.step;
            r_out.move_y         <= res_y.step;
            r_out.moved          <= (res_x.step != '0) || (res_y.step != '0);
            r_out.action_seen    <= r_changed || (res_x.step != '0) || (res_y.step != '0);
        end
    end

    // Register writes; the values are cut to the register widths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LINEAR;
            r_centre    <= CENTRE_RST;
            r_dead_zone <= '0;
            r_span      <= SPAN_RST;
            r_cursor    <= CURSOR_RST;
            r_coef_sq   <= '0;
            r_coef_lin  <= COEF_LINEAR_RST;
            r_coef_off  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MAPPING_MODE: r_mode      <= i_cfg.data[0];
                CFG_AXIS_CENTRE:  r_centre    <= i_cfg.data[ADC_BITS-1:0];
                CFG_DEAD_ZONE:    r_dead_zone <= i_cfg.data[ADC_BITS-1:0];
                CFG_AXIS_SPAN:    r_span      <= i_cfg.data[ADC_BITS-1:0];
                CFG_CURSOR_SPAN:  r_cursor    <= i_cfg.data[CUR_W-1:0];
                CFG_COEF_SQUARE:  r_coef_sq   <= $signed(i_cfg.data[COEF_W-1:0]);
                CFG_COEF_LINEAR:  r_coef_lin  <= $signed(i_cfg.data[COEF_W-1:0]);
                CFG_COEF_OFFSET:  r_coef_off  <= $signed(i_cfg.data[COEF_W-1:0]);
                default:          r_mode      <= r_mode;
            endcase
        end
    end

    jtm_axis u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_offset (x_offset),
        .i_cfg    (axis_cfg),
        .o_res    (res_x)
    );

    jtm_axis u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_offset (y_offset),
        .i_cfg    (axis_cfg),
        .o_res    (res_y)
    );

    assign i_in.ready    = in_ready;
    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import jtm_pkg::*;

    localparam int NUM_PHASES      = 19;
    localparam int ITEMS_PER_PHASE = 87;
    localparam int ADC_MAX         = (1 << ADC_BITS) - 1;

    // One complete set of mapping registers, as the testbench keeps it.
    typedef struct {
        logic    mode;
        t_adc    centre;
        t_adc    dead_zone;
        t_adc    span;
        t_cursor cursor;
        t_coef   sq;
        t_coef   lin;
        t_coef   ofs;
    } map_setting_t;

    // Keeps its own copy of the mapping registers and of the remembered
    // button level, works out the report of every accepted sample and
    // compares the reports that come out of the block against it in order.
    class move_scoreboard;
        map_setting_t cfg;
        logic         last_button;
        t_out_item    expected_steps[$];
        int unsigned  checked;
        int unsigned  errors;

        function new();
            cfg.mode      = MODE_LINEAR;
            cfg.centre    = CENTRE_RST;
            cfg.dead_zone = '0;
            cfg.span      = SPAN_RST;
            cfg.cursor    = CURSOR_RST;
            cfg.sq        = '0;
            cfg.lin       = COEF_LINEAR_RST;
            cfg.ofs       = '0;
            last_button   = 1'b0;
            checked       = 0;
            errors        = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endtask

        function void configure(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_MAPPING_MODE: cfg.mode      = v[0];
                CFG_AXIS_CENTRE:  cfg.centre    = v[ADC_BITS-1:0];
                CFG_DEAD_ZONE:    cfg.dead_zone = v[ADC_BITS-1:0];
                CFG_AXIS_SPAN:    cfg.span      = v[ADC_BITS-1:0];
                CFG_CURSOR_SPAN:  cfg.cursor    = v[CUR_W-1:0];
                CFG_COEF_SQUARE:  cfg.sq        = t_coef'(v);
                CFG_COEF_LINEAR:  cfg.lin       = t_coef'(v);
                CFG_COEF_OFFSET:  cfg.ofs       = t_coef'(v);
                default: ;
            endcase
        endfunction

        // Cursor step of one axis for a signed offset from the centre.
        function t_step axis_move(longint off);
            longint mag, r, s, m, dz;
            mag = (off < 0) ? -off : off;
            dz  = cfg.dead_zone;
            if (mag <= dz) return '0;
            if (cfg.mode == MODE_LINEAR) begin
                s = cfg.span;
                m = cfg.cursor;
                // A zero span gives no movement at all.
                if (s == 0) return '0;
                r = (off + s) * (2 * m) / (2 * s) - m;
            end else begin
                r = longint'(cfg.sq) * mag * mag + longint'(cfg.lin) * mag
                    + longint'(cfg.ofs);
                if (off < 0) r = -r;
            end
            if (r > STEP_LIMIT) r = STEP_LIMIT;
            else if (r < -STEP_LIMIT) r = -STEP_LIMIT;
            return t_step'(r);
        endfunction

        function void note_sample(t_in_item s);
            t_out_item want;
            longint    c;
            c = cfg.centre;
            want.button_changed = (s.button_level != last_button);
            want.button_now     = s.button_level;
            want.move_x         = axis_move(longint'(s.x_reading) - c);
            want.move_y         = axis_move(c - longint'(s.y_reading));
            want.moved          = (want.move_x != 0) || (want.move_y != 0);
            want.action_seen    = want.button_changed | want.moved;
            last_button         = s.button_level;
            expected_steps.push_back(want);
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            checked++;
            if (expected_steps.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
                return;
            end
            want = expected_steps.pop_front();
            if (got.button_changed !== want.button_changed)
                report($sformatf("result %0d: button_changed %b, expected %b",
                                 checked, got.button_changed, want.button_changed));
            if (got.button_now !== want.button_now)
                report($sformatf("result %0d: button_now %b, expected %b",
                                 checked, got.button_now, want.button_now));
            if (got.move_x !== want.move_x)
                report($sformatf("result %0d: move_x %0d, expected %0d",
                                 checked, got.move_x, want.move_x));
            if (got.move_y !== want.move_y)
                report($sformatf("result %0d: move_y %0d, expected %0d",
                                 checked, got.move_y, want.move_y));
            if (got.moved !== want.moved)
                report($sformatf("result %0d: moved %b, expected %b",
                                 checked, got.moved, want.moved));
            if (got.action_seen !== want.action_seen)
                report($sformatf("result %0d: action_seen %b, expected %b",
                                 checked, got.action_seen, want.action_seen));
        endtask

        function int pending();
            return expected_steps.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    jtm_in_if  in_ch ();
    jtm_out_if out_ch ();
    jtm_cfg_if cfg_ch ();

    joystick_to_mouse_mapper_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    move_scoreboard sb = new();

    // Idle rates of the two sides in percent of cycles. They follow the
    // number of accepted samples: first the sender idles less than the
    // receiver, then the other way round, and at the end neither idles.
    int unsigned tx_idle_pct = 34;
    int unsigned rx_idle_pct = 45;
    int unsigned sent_count  = 0;

    always #5 i_clk = ~i_clk;

    function automatic map_setting_t mk_setting(logic mode, int centre, int dz, int span,
                                                int cur, int sq, int lin, int ofs);
        map_setting_t s;
        s.mode      = mode;
        s.centre    = t_adc'(centre);
        s.dead_zone = t_adc'(dz);
        s.span      = t_adc'(span);
        s.cursor    = t_cursor'(cur);
        s.sq        = t_coef'(sq);
        s.lin       = t_coef'(lin);
        s.ofs       = t_coef'(ofs);
        return s;
    endfunction

    // Random register set. Half the sets keep the centre near mid-scale, and most
    // keep the dead zone, span and coefficients small, so that the steps land
    // inside the saturation limits; the rest draw every bit at random.
    function automatic map_setting_t rand_setting();
        map_setting_t s;
        s.mode   = $urandom_range(1) ? MODE_POLY : MODE_LINEAR;
        s.centre = $urandom_range(1) ? t_adc'($urandom()) : t_adc'($urandom_range(7400, 9000));
        case ($urandom_range(5))
            0:       s.dead_zone = '0;
            1:       s.dead_zone = t_adc'($urandom());
            default: s.dead_zone = t_adc'($urandom_range(1, 300));
        endcase
        s.span   = ($urandom_range(3) == 0) ? t_adc'($urandom_range(1, ADC_MAX))
                                            : t_adc'($urandom_range(1, 600));
        s.cursor = t_cursor'($urandom());
        if ($urandom_range(3) == 0) begin
            s.sq  = t_coef'($urandom());
            s.lin = t_coef'($urandom());
            s.ofs = t_coef'($urandom());
        end else begin
            s.sq  = t_coef'(int'($urandom_range(4)) - 2);
            s.lin = t_coef'(int'($urandom_range(40)) - 20);
            s.ofs = t_coef'(int'($urandom_range(40)) - 20);
        end
        return s;
    endfunction

    // ADC reading for one axis. Besides full-scale values, readings are aimed
    // close to the centre, at the edge of the dead zone and inside the span,
    // where the mapping does something other than saturate.
    function automatic t_adc pick_reading(map_setting_t s);
        longint      d, v;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25) return t_adc'($urandom_range(ADC_MAX));
        if (pick < 60) d = $urandom_range(40);
        else if (pick < 85) d = longint'(s.dead_zone) + longint'($urandom_range(2)) - 1;
        else d = $urandom_range(s.span);
        if ($urandom_range(1)) d = -d;
        v = longint'(s.centre) + d;
        if (v < 0) v = 0;
        else if (v > ADC_MAX) v = ADC_MAX;
        return t_adc'(v);
    endfunction

    // Offers one sample and waits until the block takes it. The sender may
    // idle first; valid is lowered only on those idle cycles, so a sample
    // that follows directly keeps valid high across the edge.
    task automatic send_sample(input t_in_item s);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_sample(s);
        sent_count++;
        if (sent_count < 560) begin
            tx_idle_pct = 34;
            rx_idle_pct = 45;
        end else if (sent_count < 1120) begin
            tx_idle_pct = 45;
            rx_idle_pct = 34;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic send_xy(input logic btn, input int x, input int y);
        t_in_item s;
        s.button_level = btn;
        s.x_reading    = t_adc'(x);
        s.y_reading    = t_adc'(y);
        send_sample(s);
    endtask

    // Writes one register; valid stays high so that a following write can
    // go on the next edge. The caller lowers it after the last write.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.configure(idx, v);
    endtask

    task automatic apply_setting(input map_setting_t s);
        write_reg(CFG_MAPPING_MODE, CFG_DATA_W'(s.mode));
        write_reg(CFG_AXIS_CENTRE,  CFG_DATA_W'(s.centre));
        write_reg(CFG_DEAD_ZONE,    CFG_DATA_W'(s.dead_zone));
        write_reg(CFG_AXIS_SPAN,    CFG_DATA_W'(s.span));
        write_reg(CFG_CURSOR_SPAN,  CFG_DATA_W'(s.cursor));
        write_reg(CFG_COEF_SQUARE,  CFG_DATA_W'(s.sq));
        write_reg(CFG_COEF_LINEAR,  CFG_DATA_W'(s.lin));
        write_reg(CFG_COEF_OFFSET,  CFG_DATA_W'(s.ofs));
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops offering samples and waits until every report has come back, so
    // that the block is idle before the registers change.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Receiving side. It takes reports with random stalls and, twice in the
    // run, holds ready low for a long stretch while the sender keeps going,
    // so the output register fills and the block has to stall its input.
    initial begin
        int unsigned seen;
        int unsigned hold;
        seen         = 0;
        hold         = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.payload);
                seen++;
                if (seen == 250 || seen == 1400) hold = 600;
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold != 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Main sequence: reset, a short directed part over a handful of register
    // sets, then random phases, each with its own register set.
    initial begin
        map_setting_t fixed_sets[$];
        map_setting_t cur;
        t_in_item     s;

        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_MAPPING_MODE;
        cfg_ch.data   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: readings at both ends of the scale, at rest and
        // one count either side of the centre; the button both changes and
        // holds its level.
        send_xy(1'b0, 0, 0);
        send_xy(1'b1, ADC_MAX, ADC_MAX);
        send_xy(1'b1, 8192, 8192);
        send_xy(1'b0, 8193, 8191);
        send_xy(1'b0, 8191, 8193);
        send_xy(1'b1, 0, ADC_MAX);
        drain();

        // Linear mode around a dead zone of 100: offsets on the threshold
        // give nothing, one past it gives a step; far offsets extrapolate
        // beyond the span and saturate.
        apply_setting(mk_setting(MODE_LINEAR, 8192, 100, 200, 127, 0, 1, 0));
        send_xy(1'b0, 8292, 8092);
        send_xy(1'b0, 8293, 8091);
        send_xy(1'b1, 8092, 8292);
        send_xy(1'b1, 8091, 8293);
        send_xy(1'b0, ADC_MAX, 0);
        drain();

        // Zero axis span yields no movement in linear mode.
        apply_setting(mk_setting(MODE_LINEAR, 0, 0, 0, 127, 0, 1, 0));
        send_xy(1'b1, ADC_MAX, ADC_MAX);
        send_xy(1'b0, 0, 0);
        drain();

        // Centre at the top of the scale with the widest span: full offsets
        // reach exactly the cursor span in both directions.
        apply_setting(mk_setting(MODE_LINEAR, ADC_MAX, 0, ADC_MAX, 127, 0, 1, 0));
        send_xy(1'b1, 0, 0);
        send_xy(1'b1, ADC_MAX, ADC_MAX);
        drain();

        // Polynomial mode with extreme coefficients: saturation on both
        // sides, and an offset of zero stays inside a zero dead zone.
        apply_setting(mk_setting(MODE_POLY, 8192, 0, 8192, 10, -32768, 32767, -32768));
        send_xy(1'b0, 8192, 8192);
        send_xy(1'b1, 8193, 8191);
        send_xy(1'b0, 0, ADC_MAX);
        send_xy(1'b1, 8191, 8193);
        drain();

        // Polynomial mode with small coefficients: unsaturated steps whose
        // sign follows the offset.
        apply_setting(mk_setting(MODE_POLY, 8192, 2, 8192, 10, 1, -3, 5));
        send_xy(1'b0, 8195, 8189);
        send_xy(1'b1, 8189, 8195);
        send_xy(1'b1, 8200, 8192);
        drain();

        // Register sets for the first random phases, the extremes among them.
        fixed_sets.push_back(mk_setting(MODE_LINEAR, 8192, 0, 8192, 127, 0, 1, 0));
        fixed_sets.push_back(mk_setting(MODE_LINEAR, 0, ADC_MAX, 1, 0, 0, 1, 0));
        fixed_sets.push_back(mk_setting(MODE_LINEAR, ADC_MAX, 0, 1, 127, 0, 1, 0));
        fixed_sets.push_back(mk_setting(MODE_POLY, 8192, 0, 8192, 10, 0, 1, 0));
        fixed_sets.push_back(mk_setting(MODE_POLY, 8192, 3, 8192, 10, 32767, -32768, 32767));
        fixed_sets.push_back(mk_setting(MODE_LINEAR, 8192, 0, ADC_MAX, 0, 0, 1, 0));
        fixed_sets.push_back(mk_setting(MODE_LINEAR, 8192, 10, 0, 50, 0, 1, 0));
        fixed_sets.push_back(mk_setting(MODE_POLY, 1000, 0, 500, 64, -1, 5, -32768));

        for (int p = 0; p < NUM_PHASES; p++) begin
            cur = (p < fixed_sets.size()) ? fixed_sets[p] : rand_setting();
            apply_setting(cur);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                s.button_level = $urandom_range(1);
                s.x_reading    = pick_reading(cur);
                s.y_reading    = pick_reading(cur);
                send_sample(s);
            end
            drain();
        end

        // Wait for any stray report before deciding.
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest expected run.
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
